/* hw/rtl/tbp_pkg.sv */
`timescale 1ns / 1ps
package tbp_pkg;

	typedef struct packed {
		logic        command;
		logic [31:0] branch_pc;
		logic        outcome_taken;
	} in_t;

	typedef struct packed {
		logic predict_taken;
		logic tag_hit;
	} out_t;

	localparam logic CMD_PREDICT = 1'b0;
	localparam logic CMD_UPDATE  = 1'b1;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_LOCAL_HISTORY = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOCAL_TABLES  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SHARE         = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HISTORY_BITS  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SET_BITS      = 3'd4;

	localparam logic [1:0] CNT_WEAK_NT = 2'd1;
	localparam logic [1:0] CNT_MAX     = 2'd3;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic look;
		logic clr_step;
		logic clr_row;
		logic cnt_read;
		logic finish;
	} tbp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic row_last;
		logic row_clear;
		logic out_full;
	} tbp_sts_t;

endpackage

/* hw/rtl/tbp_ctrl.sv */
`timescale 1ns / 1ps
module tbp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  tbp_pkg::tbp_sts_t sts,
	output tbp_pkg::tbp_cmd_t cmd,
	output logic              in_stall
);
	import tbp_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_ROWCLR,
		ST_ISSUE,
		ST_CNT
	} state_t;

	state_t state_q;

	always_comb begin
		cmd          = '0;
		cmd.accept   = (state_q == ST_IDLE) && in_valid;
		cmd.look     = (state_q == ST_LOOK);
		cmd.clr_step = (state_q == ST_CLEAR) || (state_q == ST_ROWCLR);
		cmd.clr_row  = (state_q == ST_ROWCLR);
		cmd.cnt_read = (state_q == ST_ISSUE);
		cmd.finish   = (state_q == ST_CNT) && !sts.out_full;
	end

	assign in_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (sts.clr_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid) state_q <= ST_LOOK;
				end
				ST_LOOK: begin
					state_q <= sts.row_clear ? ST_ROWCLR : ST_ISSUE;
				end
				ST_ROWCLR: begin
					if (sts.row_last) state_q <= ST_ISSUE;
				end
				ST_ISSUE: begin
					state_q <= ST_CNT;
				end
				ST_CNT: begin
					if (!sts.out_full) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !sts.out_full)
		else $error("result loaded over a stalled beat");
	a_accept_look: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> cmd.look)
		else $error("accepted beat not looked up");
	a_clear_end: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.clr_step && !cmd.clr_row && sts.clr_last) |=> !in_stall)
		else $error("clearing pass did not hand over to idle");
`endif

endmodule

/* hw/rtl/tbp_dp.sv */
`timescale 1ns / 1ps
module tbp_dp #(
	parameter int MAX_SETS         = 16,
	parameter int MAX_HISTORY_BITS = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  tbp_pkg::tbp_cmd_t                  cmd,
	output tbp_pkg::tbp_sts_t                  sts,
	input  tbp_pkg::in_t                       in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output tbp_pkg::out_t                      out_data,
	input  logic                               cfg_en,
	input  logic [tbp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tbp_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import tbp_pkg::*;

	localparam int HB       = MAX_HISTORY_BITS;
	localparam int SW       = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int AW       = SW + HB;
	localparam int TOTAL    = MAX_SETS << HB;
	localparam int LOG_SETS = $clog2(MAX_SETS + 1) - 1;

	// configuration
	logic       lh_q, lt_q, sh_q;
	logic [3:0] hbits_q;
	logic [2:0] sbits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lh_q    <= 1'b0;
			lt_q    <= 1'b0;
			sh_q    <= 1'b0;
			hbits_q <= 4'd8;
			sbits_q <= 3'd4;
		end else if (cfg_en) begin
			case (cfg_index)
				REG_LOCAL_HISTORY: lh_q    <= cfg_data[0];
				REG_LOCAL_TABLES:  lt_q    <= cfg_data[0];
				REG_SHARE:         sh_q    <= cfg_data[0];
				REG_HISTORY_BITS:  hbits_q <= cfg_data;
				REG_SET_BITS:      sbits_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	logic [3:0]    hb_eff, sb_eff;
	logic [HB-1:0] hmask;

	always_comb begin
		hb_eff = hbits_q;
		if (hbits_q == 4'd0) hb_eff = 4'd1;
		if (hbits_q > 4'(HB)) hb_eff = 4'(HB);
		sb_eff = 4'd0;
		if (lh_q) sb_eff = (4'(sbits_q) > 4'(LOG_SETS)) ? 4'(LOG_SETS) : 4'(sbits_q);
		hmask = ~({HB{1'b1}} << hb_eff);
	end

	// first level: tags and histories
	logic [31:0]   tag_mem  [MAX_SETS];
	logic [HB-1:0] hist_mem [MAX_SETS];
	logic [MAX_SETS-1:0] vld_q;

	logic          cmd_q, taken_q;
	logic [31:0]   pc_q;
	logic [SW-1:0] set_q;
	logic [31:0]   tag_rd_s1;
	logic [HB-1:0] hist_rd_s1;
	logic          vld_s1;
	logic [SW-1:0] set_in;

	assign set_in = SW'(in_data.branch_pc & ~(32'hffffffff << sb_eff));

	logic          hit;
	logic [31:0]   tag_cur, tag_old;
	logic [HB-1:0] h, hx, pc_low, idx, hist_new;
	logic [SW-1:0] tbl;

	always_comb begin
		tag_cur  = pc_q >> sb_eff;
		tag_old  = vld_s1 ? tag_rd_s1 : 32'd0;
		h        = (vld_s1 ? hist_rd_s1 : '0) & hmask;
		pc_low   = pc_q[HB-1:0] & hmask;
		hit      = !lh_q || (tag_old == tag_cur);
		hx       = sh_q ? (h ^ pc_low) : h;
		idx      = hit ? hx : (sh_q ? pc_low : '0);
		tbl      = lt_q ? set_q : '0;
		hist_new = hit ? (HB'({h, taken_q}) & hmask) : (HB'(taken_q) & hmask);
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cmd_q      <= in_data.command;
			pc_q       <= in_data.branch_pc;
			taken_q    <= in_data.outcome_taken;
			set_q      <= set_in;
			tag_rd_s1  <= tag_mem[set_in];
			hist_rd_s1 <= hist_mem[set_in];
			vld_s1     <= vld_q[set_in];
		end
		if (cmd.look && (cmd_q == CMD_UPDATE)) begin
			tag_mem[set_q]  <= hit ? tag_old : tag_cur;
			hist_mem[set_q] <= hist_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (cmd.look && (cmd_q == CMD_UPDATE)) begin
			vld_q[set_q] <= 1'b1;
		end
	end

	// second level: direction counters
	logic [1:0]    cnt_mem [TOTAL];
	logic [AW-1:0] clr_q, cnt_addr_q, clr_addr;
	logic          hit_q, kill_q;
	logic [1:0]    cnt_rd_s1, cnt_next;

	assign clr_addr = cmd.clr_row ? {set_q, clr_q[HB-1:0]} : clr_q;
	assign sts.clr_last  = (clr_q == AW'(TOTAL - 1));
	assign sts.row_last  = (clr_q[HB-1:0] == {HB{1'b1}});
	assign sts.row_clear = (cmd_q == CMD_UPDATE) && !hit && lt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			if (cmd.clr_row ? sts.row_last : sts.clr_last) clr_q <= '0;
			else clr_q <= clr_q + AW'(1);
		end
	end

	always_comb begin
		cnt_next = cnt_rd_s1;
		if (taken_q) begin
			if (cnt_rd_s1 != CNT_MAX) cnt_next = cnt_rd_s1 + 2'd1;
		end else begin
			if (cnt_rd_s1 != 2'd0) cnt_next = cnt_rd_s1 - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.look) begin
			cnt_addr_q <= {tbl, idx};
			hit_q      <= hit;
			kill_q     <= !hit && lt_q;
		end
		if (cmd.cnt_read) cnt_rd_s1 <= cnt_mem[cnt_addr_q];
		if (cmd.clr_step) begin
			cnt_mem[clr_addr] <= CNT_WEAK_NT;
		end else if (cmd.finish && (cmd_q == CMD_UPDATE)) begin
			cnt_mem[cnt_addr_q] <= cnt_next;
		end
	end

	// result register
	logic out_valid_q;
	out_t out_q;

	assign out_valid    = out_valid_q;
	assign out_data     = out_q;
	assign sts.out_full = out_valid_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q.predict_taken <= (cmd_q == CMD_PREDICT) && !kill_q && (cnt_rd_s1 > 2'd1);
			out_q.tag_hit       <= hit_q;
		end
	end

endmodule

/* hw/rtl/two_level_branch_predictor_top.sv */
`timescale 1ns / 1ps
// Sequence: an accepted beat passes lookup, counter read and write-back before its result
//   is valid; a tag-missing update with per-set counter tables first rewrites the set's row.
// One beat at a time: in_stall stays high through the lookup, counter read and write-back
//   sequence on the single-port counter memory; the output register frees the input.
// Reset: asynchronous, active low; afterwards a clearing pass sets all MAX_SETS *
//   2**MAX_HISTORY_BITS counters to weakly not taken while in_stall stays high.
module two_level_branch_predictor_top #(
	parameter int MAX_SETS         = 16,
	parameter int MAX_HISTORY_BITS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  tbp_pkg::in_t                   in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output tbp_pkg::out_t                  out_data,
	input  logic                           cfg_en,
	input  logic [tbp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tbp_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tbp_pkg::*;

	// command and status between the sequencer and the tables
	tbp_cmd_t cmd;
	tbp_sts_t sts;

	// sequencer: clear pass, lookup, optional row rewrite, counter read and write back
	tbp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	// history table, counter memory, config registers and the result register
	tbp_dp #(
		.MAX_SETS         (MAX_SETS),
		.MAX_HISTORY_BITS (MAX_HISTORY_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_en    (cfg_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
module testbench;
	import tbp_pkg::*;

	localparam int NUM_SETS  = 16;
	localparam int HIST_MAX  = 8;
	localparam int ROW_LEN   = 1 << HIST_MAX;
	localparam int RAND_BEATS = 1400;
	localparam int DRAIN_CYCLES = 2 * ROW_LEN + 40;
	localparam longint CYCLE_LIMIT = 3000000;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          in_valid = 1'b0;
	logic          in_stall;
	in_t           in_data = '0;
	logic          out_valid;
	logic          out_stall = 1'b0;
	out_t          out_data;
	logic          cfg_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	two_level_branch_predictor_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_en(cfg_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// Shadow copy of the predictor state and its registers.
	logic [31:0] shadow_tags [NUM_SETS];
	logic [7:0]  shadow_hist [NUM_SETS];
	logic [1:0]  shadow_ctr  [NUM_SETS * ROW_LEN];
	logic        mode_local_hist, mode_local_tbl, mode_share;
	logic [3:0]  mode_hist_bits;
	logic [2:0]  mode_set_bits;

	out_t   pending_outcomes [$];
	int     mismatch_count = 0;
	int     sender_idle_pct = 0;
	int     receiver_idle_pct = 0;
	bit     hold_receiver = 1'b0;
	longint cycle_count = 0;

	// Reset the shadow state to its power-up contents.
	function automatic void shadow_clear();
		foreach (shadow_tags[i]) shadow_tags[i] = '0;
		foreach (shadow_hist[i]) shadow_hist[i] = '0;
		foreach (shadow_ctr[i]) shadow_ctr[i] = CNT_WEAK_NT;
		mode_local_hist = 0; mode_local_tbl = 0; mode_share = 0;
		mode_hist_bits = 4'd8; mode_set_bits = 3'd4;
	endfunction

	function automatic int ctr_slot(int tbl, int idx);
		return ((mode_local_tbl ? tbl : 0) % NUM_SETS) * ROW_LEN + (idx & (ROW_LEN - 1));
	endfunction

	function automatic void bump_counter(int tbl, int idx, bit taken);
		int s;
		s = ctr_slot(tbl, idx);
		if (taken && shadow_ctr[s] != CNT_MAX) shadow_ctr[s]++;
		else if (!taken && shadow_ctr[s] != 2'd0) shadow_ctr[s]--;
	endfunction

	// Advance the shadow state by one beat and return the result it yields.
	function automatic out_t predict_branch(in_t req);
		int hb, sb, set_idx, ent, h, pc_low;
		logic [31:0] tag;
		bit hit;
		out_t res;
		hb = (mode_hist_bits < 1) ? 1 : (mode_hist_bits > HIST_MAX) ? HIST_MAX : mode_hist_bits;
		sb = mode_local_hist ? mode_set_bits : 0;
		while (sb > 0 && (1 << sb) > NUM_SETS) sb--;
		set_idx = req.branch_pc & ((1 << sb) - 1);
		tag = req.branch_pc >> sb;
		pc_low = req.branch_pc & ((1 << hb) - 1);
		ent = mode_local_hist ? set_idx : 0;
		hit = !mode_local_hist || shadow_tags[ent] == tag;
		res = '0;
		res.tag_hit = hit;
		if (req.command == CMD_PREDICT) begin
			if (hit) begin
				h = shadow_hist[ent] & ((1 << hb) - 1);
				if (mode_share) h ^= pc_low;
				res.predict_taken = shadow_ctr[ctr_slot(ent, h)] > 1;
			end else if (!mode_local_tbl) begin
				res.predict_taken = shadow_ctr[ctr_slot(0, mode_share ? pc_low : 0)] > 1;
			end
		end else if (hit) begin
			h = shadow_hist[ent] & ((1 << hb) - 1);
			shadow_hist[ent] = 8'(((h << 1) | req.outcome_taken) & ((1 << hb) - 1));
			if (mode_share) h ^= pc_low;
			bump_counter(ent, h, req.outcome_taken);
		end else begin
			if (mode_local_tbl)
				for (int i = 0; i < ROW_LEN; i++) shadow_ctr[ctr_slot(set_idx, i)] = CNT_WEAK_NT;
			bump_counter(set_idx, mode_share ? pc_low : 0, req.outcome_taken);
			shadow_tags[set_idx] = tag;
			shadow_hist[set_idx] = 8'(req.outcome_taken & ((1 << hb) - 1));
		end
		return res;
	endfunction

	// Write one register, on the port and in the shadow copy.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_en <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_en <= 1'b0;
		case (idx)
			REG_LOCAL_HISTORY: mode_local_hist = val[0];
			REG_LOCAL_TABLES:  mode_local_tbl = val[0];
			REG_SHARE:         mode_share = val[0];
			REG_HISTORY_BITS:  mode_hist_bits = val;
			REG_SET_BITS:      mode_set_bits = val[2:0];
			default: ;
		endcase
	endtask

	task automatic set_mode(bit lh, bit lt, bit sh, int hb, int sb);
		write_reg(REG_LOCAL_HISTORY, CFG_DATA_W'(lh));
		write_reg(REG_LOCAL_TABLES, CFG_DATA_W'(lt));
		write_reg(REG_SHARE, CFG_DATA_W'(sh));
		write_reg(REG_HISTORY_BITS, CFG_DATA_W'(hb));
		write_reg(REG_SET_BITS, CFG_DATA_W'(sb));
	endtask

	// Offer one beat, then hold it until the block takes it; drop valid only while idling.
	task automatic send_beat(in_t req);
		while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_outcomes.push_back(predict_branch(req));
	endtask

	// Wait for every expected result, then let a row rewrite finish.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_outcomes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic in_t make_beat(bit cmd, logic [31:0] pc, bit taken);
		in_t r;
		r.command = cmd; r.branch_pc = pc; r.outcome_taken = taken;
		return r;
	endfunction

	// Random beat: mostly addresses from a small pool so histories train and tags hit.
	function automatic in_t random_beat();
		logic [31:0] pc;
		case ($urandom_range(9))
			0: pc = $urandom();
			1: pc = $urandom_range(1) ? 32'hffff_fff0 | $urandom_range(15) : $urandom_range(15);
			default: pc = {28'(28'h00a_b3c0 + $urandom_range(3)), 4'($urandom_range(15))};
		endcase
		return make_beat(1'($urandom_range(1)), pc, 1'($urandom_range(1)));
	endfunction

	// Receiver: stall at random, or hold off for a long stretch on request.
	always @(posedge clk) begin
		if (hold_receiver) out_stall <= 1'b1;
		else out_stall <= (receiver_idle_pct > 0) && ($urandom_range(99) < receiver_idle_pct);
	end

	// Check each result beat against the oldest expectation.
	always @(posedge clk) begin
		out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_outcomes.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) $display("unexpected result beat %p", out_data);
			end else begin
				want = pending_outcomes.pop_front();
				if (out_data.predict_taken !== want.predict_taken
					|| out_data.tag_hit !== want.tag_hit) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected taken=%0b hit=%0b, got taken=%0b hit=%0b",
							want.predict_taken, want.tag_hit,
							out_data.predict_taken, out_data.tag_hit);
				end
			end
		end
	end

	// Timeout watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	typedef struct {
		bit          cmd;
		logic [31:0] pc;
		bit          taken;
		bit          known;
		out_t        result;
	} stim_row_t;

	stim_row_t directed [] = '{
		// after reset: global history, counters weakly not taken
		'{CMD_PREDICT, 32'h0000_0000, 1'b0, 1'b1, '{1'b0, 1'b1}},
		'{CMD_PREDICT, 32'hffff_ffff, 1'b1, 1'b1, '{1'b0, 1'b1}},
		'{CMD_UPDATE,  32'h0000_0000, 1'b1, 1'b1, '{1'b0, 1'b1}},
		'{CMD_UPDATE,  32'hffff_ffff, 1'b0, 1'b1, '{1'b0, 1'b1}},
		'{CMD_UPDATE,  32'h8000_0001, 1'b1, 1'b0, '0},
		'{CMD_PREDICT, 32'h8000_0001, 1'b0, 1'b0, '0},
		'{CMD_UPDATE,  32'h5555_5555, 1'b1, 1'b0, '0},
		'{CMD_UPDATE,  32'haaaa_aaaa, 1'b1, 1'b0, '0},
		'{CMD_PREDICT, 32'h5555_5555, 1'b1, 1'b0, '0}
	};

	stim_row_t local_rows [] = '{
		// local history, all tags zero: address with nonzero tag misses
		'{CMD_PREDICT, 32'h0000_0013, 1'b0, 1'b0, '0},
		'{CMD_UPDATE,  32'h0000_0013, 1'b1, 1'b1, '{1'b0, 1'b0}},
		'{CMD_UPDATE,  32'h0000_0013, 1'b1, 1'b1, '{1'b0, 1'b1}},
		'{CMD_PREDICT, 32'h0000_0013, 1'b0, 1'b0, '0},
		'{CMD_PREDICT, 32'h0000_0003, 1'b0, 1'b1, '{1'b0, 1'b0}},
		'{CMD_UPDATE,  32'hffff_ffff, 1'b0, 1'b0, '0},
		'{CMD_PREDICT, 32'hffff_ffff, 1'b0, 1'b0, '0},
		'{CMD_UPDATE,  32'h0000_0000, 1'b1, 1'b0, '0},
		'{CMD_PREDICT, 32'h0000_0000, 1'b0, 1'b0, '0}
	};

	task automatic run_rows(stim_row_t rows []);
		foreach (rows[i]) begin
			if (rows[i].known) begin
				// the typed result must agree with the shadow once the beat is sent
				in_t probe;
				probe = make_beat(rows[i].cmd, rows[i].pc, rows[i].taken);
				send_beat(probe);
				if (pending_outcomes[$] !== rows[i].result) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("directed row %0d: expected %p, table gives %p",
							i, pending_outcomes[$], rows[i].result);
				end
			end else begin
				send_beat(make_beat(rows[i].cmd, rows[i].pc, rows[i].taken));
			end
		end
	endtask

	task automatic random_phase(int count);
		repeat (count) send_beat(random_beat());
	endtask

	initial begin
		shadow_clear();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		sender_idle_pct = 6;
		receiver_idle_pct = 74;
		run_rows(directed);
		wait_idle();
		// local histories with per-set tables and an out-of-range set width
		set_mode(1, 1, 0, 8, 7);
		run_rows(local_rows);
		wait_idle();
		// three set bits give the same addresses fresh tags, so they miss again
		set_mode(1, 0, 1, 0, 3);
		run_rows(local_rows);
		wait_idle();

		set_mode(0, 0, 1, 8, 0);
		random_phase(RAND_BEATS / 5);
		wait_idle();

		// long receiver hold-off while beats keep coming
		sender_idle_pct = 74;
		receiver_idle_pct = 6;
		set_mode(1, 1, 1, 3, 2);
		hold_receiver = 1'b1;
		fork
			begin
				random_phase(20);
				in_valid <= 1'b0;
			end
			begin
				repeat (300) @(posedge clk);
				hold_receiver = 1'b0;
			end
		join
		random_phase(RAND_BEATS / 5 - 20);
		wait_idle();

		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		set_mode(1, 0, 0, 15, 1);
		random_phase(RAND_BEATS / 5);
		wait_idle();
		set_mode(1, 1, 0, 1, 4);
		random_phase(RAND_BEATS / 5);
		wait_idle();
		set_mode(0, 1, 1, 8, 3);
		random_phase(RAND_BEATS / 5);
		wait_idle();

		if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
